// ===== hdl/can_id_range_filter_table_unit_assert.svh =====
// Assertion macros for the CAN identifier range filter table.
`ifndef CAN_ID_RANGE_FILTER_TABLE_UNIT_ASSERT_SVH
`define CAN_ID_RANGE_FILTER_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define CANFLT_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define CANFLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/canflt_pkg.sv =====
// Shared types, constants and helpers of the CAN identifier range filter table.
`default_nettype none

package canflt_pkg;

	localparam int FILTER_ENTRIES = 16;
	localparam int IDX_W = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FILTER_ENTRIES + 1);
	localparam int USED_W = 5;
	localparam int USED_MAX = 31;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FILTER_ENTRIES);

	localparam logic [2:0] ACT_CLEAR = 3'd0;
	localparam logic [2:0] ACT_ADD = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_FRAME = 3'd3;
	localparam logic [2:0] ACT_BUS = 3'd4;

	localparam logic [2:0] BUS_ANY = 3'd0;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_MISSING = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  bus;
		logic [31:0] id_from;
		logic [31:0] id_to;
		logic [31:0] frame_id;
	} req_beat_t;

	typedef struct packed {
		logic              passed;
		logic [1:0]        status;
		logic [USED_W-1:0] entries_used;
	} rsp_beat_t;

	typedef struct packed {
		logic [2:0]  bus;
		logic [31:0] low;
		logic [31:0] high;
	} entry_t;

	typedef struct packed {
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic             clr_valid;
		logic             clr_all;
		logic [IDX_W-1:0] wr_idx;
		entry_t           wr_entry;
	} tbl_ctl_t;

	function automatic logic [USED_W-1:0] sat_used(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+USED_W-1:0] wide;
		wide = (CNT_W + USED_W)'(cnt);
		if (wide > (CNT_W + USED_W)'(USED_MAX))
			return USED_W'(USED_MAX);
		return wide[USED_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/canflt_table.sv =====
// Filter entry storage: entry memory with registered read and per-entry valid flags.
`default_nettype none

module canflt_table
	import canflt_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tbl_ctl_t                  ctl,
	output entry_t                         rd_entry,
	output logic [FILTER_ENTRIES-1:0]      valid
);

	entry_t mem_q [FILTER_ENTRIES];
	entry_t rd_q;
	logic [FILTER_ENTRIES-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			mem_q[ctl.wr_idx] <= ctl.wr_entry;
		rd_q <= mem_q[ctl.rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr_all) begin
			valid_q <= '0;
		end else begin
			if (ctl.wr_en)
				valid_q[ctl.wr_idx] <= 1'b1;
			if (ctl.clr_valid)
				valid_q[ctl.wr_idx] <= 1'b0;
		end
	end

	assign rd_entry = rd_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ===== hdl/canflt_cmp.sv =====
// Shared per-entry compare unit: decides whether one table entry hits for the current action.
`default_nettype none

module canflt_cmp
	import canflt_pkg::*;
(
	input  wire req_beat_t item,
	input  wire entry_t    ent,
	input  wire logic      ent_valid,
	output logic           hit
);

	logic bus_eq;
	logic in_range;

	assign bus_eq = (ent.bus == item.bus);
	assign in_range = (item.frame_id >= ent.low) && (item.frame_id <= ent.high);

	always_comb begin
		unique case (item.action)
			ACT_ADD:    hit = !ent_valid;
			ACT_REMOVE: hit = ent_valid && bus_eq && (ent.low == item.id_from)
				&& (ent.high == item.id_to);
			ACT_FRAME:  hit = ent_valid && ((ent.bus == BUS_ANY) || bus_eq) && in_range;
			ACT_BUS:    hit = ent_valid && (ent.bus != BUS_ANY) && bus_eq;
			default:    hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/can_id_range_filter_table_unit.sv =====
// Clear and answers known from the fill count go from ST_IDLE straight to ST_DONE.
// Scanned actions pass through ST_SCAN first; ST_DONE loads rsp unless it is stalled.
// The table is walked one entry per cycle through the single memory read port and
// one compare unit; req_stall stays high from acceptance until the result is loaded.
// A new item is taken only once the previous result has been loaded into rsp.
// Reset: asynchronous, empties the table at once (valid flags cleared); no clearing pass.
`default_nettype none

module can_id_range_filter_table_unit
	import canflt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_beat_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_beat_t      rsp
);

	`include "can_id_range_filter_table_unit_assert.svh"

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                    state_q;
	req_beat_t                 item_q;
	logic [IDX_W-1:0]          idx_q;
	logic                      issue_q;
	logic                      chk_s1;
	logic [IDX_W-1:0]          idx_s1;
	logic                      passed_q;
	logic [1:0]                status_q;
	logic [CNT_W-1:0]          cnt_q;
	rsp_beat_t                 rsp_q;
	logic                      rsp_valid_q;

	tbl_ctl_t                  ctl;
	entry_t                    rd_entry;
	logic [FILTER_ENTRIES-1:0] valid;
	logic                      hit;
	logic                      accept;
	logic                      scan_hit;

	assign accept = req_valid && !req_stall;
	assign scan_hit = (state_q == ST_SCAN) && chk_s1 && hit;

	always_comb begin
		ctl.rd_idx = idx_q;
		ctl.wr_idx = idx_s1;
		ctl.wr_entry.bus = item_q.bus;
		ctl.wr_entry.low = item_q.id_from;
		ctl.wr_entry.high = item_q.id_to;
		ctl.wr_en = scan_hit && (item_q.action == ACT_ADD);
		ctl.clr_valid = scan_hit && (item_q.action == ACT_REMOVE);
		ctl.clr_all = accept && (req.action == ACT_CLEAR);
	end

	canflt_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rd_entry (rd_entry),
		.valid    (valid)
	);

	canflt_cmp u_cmp (
		.item      (item_q),
		.ent       (rd_entry),
		.ent_valid (valid[idx_s1]),
		.hit       (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			item_q <= '0;
			idx_q <= '0;
			issue_q <= 1'b0;
			chk_s1 <= 1'b0;
			idx_s1 <= '0;
			passed_q <= 1'b0;
			status_q <= STAT_OK;
			cnt_q <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= req;
						idx_q <= '0;
						issue_q <= 1'b1;
						chk_s1 <= 1'b0;
						passed_q <= 1'b0;
						status_q <= STAT_OK;
						state_q <= ST_DONE;
						unique case (req.action)
							ACT_CLEAR: cnt_q <= '0;
							ACT_ADD: begin
								if (cnt_q == CNT_FULL)
									status_q <= STAT_FULL;
								else
									state_q <= ST_SCAN;
							end
							ACT_REMOVE: begin
								if (cnt_q == '0)
									status_q <= STAT_MISSING;
								else
									state_q <= ST_SCAN;
							end
							ACT_FRAME: begin
								if (cnt_q == '0)
									passed_q <= 1'b1;
								else
									state_q <= ST_SCAN;
							end
							ACT_BUS: begin
								if (cnt_q == '0 || req.bus == BUS_ANY)
									passed_q <= 1'b1;
								else
									state_q <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					chk_s1 <= issue_q;
					if (issue_q) begin
						idx_s1 <= idx_q;
						if (idx_q == LAST_IDX)
							issue_q <= 1'b0;
						else
							idx_q <= idx_q + IDX_W'(1);
					end
					if (chk_s1) begin
						if (hit) begin
							unique case (item_q.action)
								ACT_ADD:    cnt_q <= cnt_q + CNT_W'(1);
								ACT_REMOVE: cnt_q <= cnt_q - CNT_W'(1);
								default:    passed_q <= 1'b1;
							endcase
							chk_s1 <= 1'b0;
							issue_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (idx_s1 == LAST_IDX) begin
							unique case (item_q.action)
								ACT_ADD:    status_q <= STAT_FULL;
								ACT_REMOVE: status_q <= STAT_MISSING;
								default:    ;
							endcase
							chk_s1 <= 1'b0;
							issue_q <= 1'b0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.passed <= passed_q;
						rsp_q.status <= status_q;
						rsp_q.entries_used <= sat_used(cnt_q);
						rsp_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`CANFLT_ASSERT_NEXT(a_busy_after_accept, accept, req_stall, "not busy after accepted beat")
	`CANFLT_ASSERT(a_cnt_flags, 1'b1, $countones(valid) == int'(cnt_q), "count vs valid flags")
	`CANFLT_ASSERT(a_count_bound, 1'b1, cnt_q <= CNT_FULL, "fill count beyond table depth")
	`CANFLT_ASSERT(a_rsp_from_done, $rose(rsp_valid), $past(state_q) == ST_DONE, "early result")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the CAN identifier range filter table: directed rows, then random traffic.
`timescale 1ns / 100ps

module tb
	import canflt_pkg::*;
();

	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 725;
	localparam int GAP_PCT = 29;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX = 10;
	localparam int DIR_ROWS = 25;

	typedef struct packed {
		req_beat_t req;
		logic      fixed_rsp;
		rsp_beat_t rsp;
	} dir_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	logic gaps_on = 1'b1;
	logic hold_req = 1'b0;
	logic rsp_hold = 1'b0;
	int   mismatches = 0;
	int   cycles = 0;

	logic        flt_valid [FILTER_ENTRIES];
	logic [2:0]  flt_bus   [FILTER_ENTRIES];
	logic [31:0] flt_low   [FILTER_ENTRIES];
	logic [31:0] flt_high  [FILTER_ENTRIES];

	rsp_beat_t rsp_expected [$];
	rsp_beat_t rsp_want;
	dir_row_t  dir_rows [DIR_ROWS];

	can_id_range_filter_table_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int used_count();
		int n;
		n = 0;
		for (int i = 0; i < FILTER_ENTRIES; i++)
			if (flt_valid[i])
				n++;
		return n;
	endfunction

	function automatic rsp_beat_t filter_apply(input req_beat_t r);
		rsp_beat_t o;
		logic      hit;
		int        n;
		o = '0;
		hit = 1'b0;
		case (r.action)
			ACT_CLEAR: begin
				for (int i = 0; i < FILTER_ENTRIES; i++)
					flt_valid[i] = 1'b0;
			end
			ACT_ADD: begin
				o.status = STAT_FULL;
				for (int i = 0; i < FILTER_ENTRIES; i++)
					if (!hit && !flt_valid[i]) begin
						flt_valid[i] = 1'b1;
						flt_bus[i] = r.bus;
						flt_low[i] = r.id_from;
						flt_high[i] = r.id_to;
						o.status = STAT_OK;
						hit = 1'b1;
					end
			end
			ACT_REMOVE: begin
				o.status = STAT_MISSING;
				for (int i = 0; i < FILTER_ENTRIES; i++)
					if (!hit && flt_valid[i] && flt_bus[i] == r.bus &&
					    flt_low[i] == r.id_from && flt_high[i] == r.id_to) begin
						flt_valid[i] = 1'b0;
						o.status = STAT_OK;
						hit = 1'b1;
					end
			end
			ACT_FRAME: begin
				if (used_count() == 0)
					o.passed = 1'b1;
				for (int i = 0; i < FILTER_ENTRIES; i++)
					if (flt_valid[i] && (flt_bus[i] == BUS_ANY || flt_bus[i] == r.bus) &&
					    r.frame_id >= flt_low[i] && r.frame_id <= flt_high[i])
						o.passed = 1'b1;
			end
			ACT_BUS: begin
				if (used_count() == 0 || r.bus == BUS_ANY)
					o.passed = 1'b1;
				for (int i = 0; i < FILTER_ENTRIES; i++)
					if (flt_valid[i] && flt_bus[i] != BUS_ANY && flt_bus[i] == r.bus)
						o.passed = 1'b1;
			end
			default: ;
		endcase
		n = used_count();
		o.entries_used = (n > USED_MAX) ? USED_W'(USED_MAX) : USED_W'(n);
		return o;
	endfunction

	function automatic int pick_live_slot();
		int n;
		int k;
		n = used_count();
		if (n == 0)
			return -1;
		k = $urandom_range(n - 1);
		for (int i = 0; i < FILTER_ENTRIES; i++)
			if (flt_valid[i]) begin
				if (k == 0)
					return i;
				k--;
			end
		return -1;
	endfunction

	function automatic req_beat_t next_random_item(input int add_pct);
		req_beat_t r;
		int        roll;
		int        slot;
		r.action = ACT_CLEAR;
		r.bus = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
		r.frame_id = $urandom;
		case ($urandom_range(5))
			0: begin
				r.id_from = $urandom;
				r.id_to = $urandom;
			end
			1: begin
				r.id_from = '0;
				r.id_to = 32'hFFFF_FFFF;
			end
			2: begin
				r.id_from = $urandom;
				r.id_to = r.id_from + $urandom_range(4095);
			end
			3: begin
				r.id_from = $urandom_range(2047);
				r.id_to = r.id_from;
			end
			default: begin
				r.id_from = $urandom_range(2047);
				r.id_to = r.id_from + $urandom_range(255);
			end
		endcase
		roll = $urandom_range(99);
		slot = pick_live_slot();
		if (roll < 2) begin
			r.action = ACT_CLEAR;
		end else if (roll < 5) begin
			r.action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
		end else if (roll < 5 + add_pct) begin
			r.action = ACT_ADD;
		end else if (roll < 20 + add_pct) begin
			r.action = ACT_REMOVE;
			if (slot >= 0 && $urandom_range(99) < 80) begin
				r.bus = flt_bus[slot];
				r.id_from = flt_low[slot];
				r.id_to = flt_high[slot];
				if ($urandom_range(9) == 0)
					r.id_to = r.id_to ^ (32'h1 << $urandom_range(31));
			end
		end else if ($urandom_range(99) < 70) begin
			r.action = ACT_FRAME;
			if (slot >= 0 && $urandom_range(99) < 85) begin
				if ($urandom_range(99) < 70)
					r.bus = flt_bus[slot];
				case ($urandom_range(5))
					0: r.frame_id = flt_low[slot] - 1;
					1: r.frame_id = flt_low[slot];
					2: r.frame_id = flt_high[slot];
					3: r.frame_id = flt_high[slot] + 1;
					4: r.frame_id = flt_low[slot] + ((flt_high[slot] - flt_low[slot]) >> 1);
					default: ;
				endcase
			end
		end else begin
			r.action = ACT_BUS;
			r.bus = 3'($urandom_range(7));
		end
		return r;
	endfunction

	task automatic send_beat(input req_beat_t r, input logic use_fixed, input rsp_beat_t fixed);
		rsp_beat_t p;
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		p = filter_apply(r);
		rsp_expected.insert(rsp_expected.size(), use_fixed ? fixed : p);
	endtask

	always @(negedge clk)
		rsp_stall <= rsp_hold || (gaps_on && $urandom_range(99) < GAP_PCT);

	// long receiver hold-off so the block backs up onto its input
	initial begin
		wait (hold_req);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		rsp_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected beat: passed=%0d status=%0d used=%0d",
						rsp.passed, rsp.status, rsp.entries_used);
				mismatches <= mismatches + 1;
			end else begin
				rsp_want = rsp_expected.pop_front();
				if (rsp.passed !== rsp_want.passed || rsp.status !== rsp_want.status ||
				    rsp.entries_used !== rsp_want.entries_used) begin
					if (mismatches < REPORT_MAX)
						$display("mismatch: passed %0d/%0d status %0d/%0d used %0d/%0d (exp/act)",
							rsp_want.passed, rsp.passed, rsp_want.status, rsp.status,
							rsp_want.entries_used, rsp.entries_used);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

	initial begin
		int add_pct;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		add_pct = 30;
		for (int i = 0; i < FILTER_ENTRIES; i++) begin
			flt_valid[i] = 1'b0;
			flt_bus[i] = '0;
			flt_low[i] = '0;
			flt_high[i] = '0;
		end
		dir_rows = '{
			'{'{ACT_FRAME, BUS_ANY, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, STAT_OK, 5'd0}},
			'{'{ACT_BUS, 3'd4, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, STAT_OK, 5'd0}},
			'{'{ACT_REMOVE, BUS_ANY, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, STAT_MISSING, 5'd0}},
			'{'{ACT_CLEAR, BUS_ANY, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, STAT_OK, 5'd0}},
			'{'{ACT_ADD, BUS_ANY, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1, '{1'b0, STAT_OK, 5'd1}},
			'{'{ACT_FRAME, 3'd4, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0},
			'{'{ACT_ADD, 3'd3, 32'h100, 32'h1FF, 32'h0}, 1'b0, '0},
			'{'{ACT_ADD, 3'd2, 32'h500, 32'h400, 32'h0}, 1'b0, '0},
			'{'{ACT_REMOVE, BUS_ANY, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1, '{1'b0, STAT_OK, 5'd2}},
			'{'{ACT_FRAME, 3'd2, 32'h0, 32'h0, 32'h450}, 1'b0, '0},
			'{'{ACT_FRAME, BUS_ANY, 32'h0, 32'h0, 32'h150}, 1'b0, '0},
			'{'{ACT_FRAME, 3'd3, 32'h0, 32'h0, 32'h1FF}, 1'b0, '0},
			'{'{ACT_FRAME, 3'd3, 32'h0, 32'h0, 32'h200}, 1'b0, '0},
			'{'{ACT_BUS, BUS_ANY, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, STAT_OK, 5'd2}},
			'{'{ACT_BUS, 3'd3, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
			'{'{ACT_BUS, 3'd1, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
			'{'{ACT_ADD, 3'd7, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
			'{'{ACT_BUS, 3'd7, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
			'{'{ACT_FRAME, 3'd7, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
			'{'{ACT_ADD, 3'd3, 32'h100, 32'h1FF, 32'h0}, 1'b0, '0},
			'{'{ACT_REMOVE, 3'd3, 32'h100, 32'h1FF, 32'h0}, 1'b0, '0},
			'{'{ACT_FRAME, 3'd3, 32'h0, 32'h0, 32'h100}, 1'b0, '0},
			'{'{ACT_SPARE_LO, 3'd5, 32'hFFFF_FFFF, 32'h0, 32'h100}, 1'b0, '0},
			'{'{ACT_SPARE_HI, 3'd7, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b0, '0},
			'{'{ACT_CLEAR, BUS_ANY, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, STAT_OK, 5'd0}}
		};
		repeat (6)
			@(negedge clk);
		arst_n = 1'b1;
		for (int k = 0; k < DIR_ROWS; k++)
			send_beat(dir_rows[k].req, dir_rows[k].fixed_rsp, dir_rows[k].rsp);
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 50 == 0)
				case ($urandom_range(2))
					0: add_pct = 10;
					1: add_pct = 30;
					default: add_pct = 55;
				endcase
			if (k == 250)
				hold_req <= 1'b1;
			if (k == 400)
				gaps_on <= 1'b0;
			if (k == 520)
				gaps_on <= 1'b1;
			send_beat(next_random_item(add_pct), 1'b0, '0);
		end
		@(negedge clk);
		req_valid <= 1'b0;
		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
